// File: rtl/csvp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvp_pkg - shared types and constants of the CSV field parser
// Result kinds, parse states, register map and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package csvp_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned ROW_W     = 32;
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned APB_DW    = 32;
	localparam int unsigned APB_AW    = 4;
	localparam int unsigned QDEPTH_DEF = 4;

	// Character constants
	localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
	localparam logic [BYTE_W-1:0] CH_COMMA = 8'd44;
	localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'd34;

	localparam logic [ROW_W-1:0] ROW_FIRST = 32'd1;
	localparam logic [ROW_W-1:0] ROW_MAX   = 32'hFFFF_FFFF;

	// Register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_SEPARATOR = 2'd0;
	localparam logic [1:0] REG_QUOTE     = 2'd1;
	localparam logic [1:0] REG_LAZY      = 2'd2;

	typedef enum logic [KIND_W-1:0] {
		KIND_BYTE  = 2'd0,
		KIND_FIELD = 2'd1,
		KIND_ROW   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		MODE_PLAIN  = 2'd0,
		MODE_QUOTED = 2'd1,
		MODE_QPEND  = 2'd2,
		MODE_CRSEEN = 2'd3
	} mode_t;

	// One accepted byte's results: a first result, plus an optional
	// end-of-row flush that always follows it on the same row.
	typedef struct packed {
		logic              two;
		kind_t             kind0;
		logic [BYTE_W-1:0] byte0;
		logic [ROW_W-1:0]  row;
	} entry_t;

	typedef struct packed {
		logic [BYTE_W-1:0] separator;
		logic [BYTE_W-1:0] quote_byte;
		logic              lazy_quotes;
	} cfg_t;

endpackage

// File: rtl/csvp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvp_if - stream channels of the CSV field parser
// Input byte channel and output result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface csvp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_data;

	modport source (output valid, data_byte, end_of_data, input ready);
	modport sink   (input valid, data_byte, end_of_data, output ready);
endinterface

interface csvp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  out_byte;
	logic [31:0] row_number;
	logic        last_result;

	modport source (output valid, kind, out_byte, row_number, last_result, input ready);
	modport sink   (input valid, kind, out_byte, row_number, last_result, output ready);
endinterface

// File: rtl/csv_field_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_field_parser_top - byte-serial CSV field splitter
//
// in_ch takes one byte of CSV text per transfer, end_of_data marking the
// last byte of a document. out_ch gives content bytes (kind 0), end of
// field (kind 1) and end of field and row (kind 2), each tagged with its
// 1-based row; last_result flags the final result caused by a byte.
// The APB port sets separator (0x0), quote character (0x4) and lazy quote
// mode (0x8); write it only while no bytes are in flight.
// Throughput: one input byte per cycle while the queue has room. Results
// pass through the queue and then the output register; out_ch gives one
// result per cycle while it is ready, so a byte with two results occupies
// the output for both, and a queue of QUEUE_DEPTH entries absorbs the
// difference. A stall on out_ch fills the queue, then in_ch drops ready.
// Reset restores comma, double quote, strict mode, row 1 and empties
// the queue; the block is ready for bytes as soon as reset is released.
// ----------------------------------------------------------------------------
module csv_field_parser_top #(
	parameter int unsigned QUEUE_DEPTH = csvp_pkg::QDEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	csvp_in_if.sink                     in_ch,
	csvp_out_if.source                  out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [csvp_pkg::APB_AW-1:0] paddr,
	input  logic [csvp_pkg::APB_DW-1:0] pwdata,
	output logic [csvp_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import csvp_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;
	logic       q_full, q_empty, q_push, q_pop;
	entry_t     q_entry, q_head;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.separator   <= CH_COMMA;
			cfg_q.quote_byte  <= CH_DQUOTE;
			cfg_q.lazy_quotes <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SEPARATOR: cfg_q.separator   <= pwdata[BYTE_W-1:0];
				REG_QUOTE:     cfg_q.quote_byte  <= pwdata[BYTE_W-1:0];
				REG_LAZY:      cfg_q.lazy_quotes <= pwdata[0];
				default:       cfg_q             <= cfg_q;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (reg_idx)
			REG_SEPARATOR: prdata = {{(APB_DW-BYTE_W){1'b0}}, cfg_q.separator};
			REG_QUOTE:     prdata = {{(APB_DW-BYTE_W){1'b0}}, cfg_q.quote_byte};
			REG_LAZY:      prdata = {{(APB_DW-1){1'b0}}, cfg_q.lazy_quotes};
			default:       prdata = '0;
		endcase
	end

	csvp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_ch   (in_ch),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (q_entry)
	);

	csvp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty)
	);

	csvp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (q_head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);

endmodule

// File: rtl/csvp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvp_front - byte classifier and parse state
// Takes one byte per cycle while the queue is not full, updates quote/row
// state, pushes one queue entry per byte that produces results.
// ----------------------------------------------------------------------------
module csvp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  csvp_pkg::cfg_t  cfg,
	csvp_in_if.sink         in_ch,
	input  logic            q_full,
	output logic            q_push,
	output csvp_pkg::entry_t q_entry
);
	import csvp_pkg::*;

	mode_t             mode_q, mode_d;
	logic              fne_q, fne_d;
	logic [ROW_W-1:0]  row_q, row_d;

	logic              accept;
	logic [BYTE_W-1:0] c;
	logic              eod;
	logic              is_quote, is_sep, is_nl;
	logic              plain;
	logic              row_ended;
	logic              res0_valid;
	kind_t             res0_kind;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign c           = in_ch.data_byte;
	assign eod         = in_ch.end_of_data;

	// Byte classes; separator beats CR/LF, quote beats separator
	assign is_quote = (c == cfg.quote_byte);
	assign is_sep   = !is_quote && (c == cfg.separator);
	assign is_nl    = !is_quote && !is_sep && ((c == CH_CR) || (c == CH_LF));

	// Byte takes the unquoted path
	always_comb begin
		case (mode_q)
			MODE_PLAIN:  plain = 1'b1;
			MODE_QPEND:  plain = !is_quote;
			MODE_CRSEEN: plain = (c != CH_LF);
			default:     plain = 1'b0;
		endcase
	end

	// Next state
	always_comb begin
		mode_d = mode_q;
		fne_d  = fne_q;
		row_d  = row_q;
		case (mode_q)
			MODE_QPEND: begin
				if (is_quote) begin
					fne_d  = 1'b1;
					mode_d = MODE_QUOTED;
				end else begin
					mode_d = MODE_PLAIN;
				end
			end
			MODE_CRSEEN: begin
				mode_d = MODE_PLAIN;
			end
			MODE_QUOTED: begin
				if (is_quote) begin
					mode_d = MODE_QPEND;
				end else begin
					fne_d = 1'b1;
				end
			end
			default: begin
				mode_d = mode_q;
			end
		endcase
		if (plain) begin
			if (is_quote) begin
				if (!(cfg.lazy_quotes && fne_q)) begin
					mode_d = MODE_QUOTED;
				end
			end else if (is_sep) begin
				fne_d = 1'b0;
			end else if (is_nl) begin
				fne_d  = 1'b0;
				row_d  = (row_q == ROW_MAX) ? row_q : row_q + ROW_FIRST;
				mode_d = (c == CH_CR) ? MODE_CRSEEN : MODE_PLAIN;
			end else begin
				fne_d = 1'b1;
			end
		end
		if (eod) begin
			mode_d = MODE_PLAIN;
			fne_d  = 1'b0;
			row_d  = ROW_FIRST;
		end
	end

	// Results of this byte
	always_comb begin
		res0_valid = 1'b0;
		res0_kind  = KIND_BYTE;
		row_ended  = 1'b0;
		case (mode_q)
			MODE_QPEND:  res0_valid = is_quote;
			MODE_CRSEEN: row_ended  = (c == CH_LF);
			MODE_QUOTED: res0_valid = !is_quote;
			default:     res0_valid = 1'b0;
		endcase
		if (plain) begin
			if (is_quote) begin
				res0_valid = cfg.lazy_quotes && fne_q;
			end else if (is_sep) begin
				res0_valid = 1'b1;
				res0_kind  = KIND_FIELD;
			end else if (is_nl) begin
				res0_valid = 1'b1;
				res0_kind  = KIND_ROW;
				row_ended  = 1'b1;
			end else begin
				res0_valid = 1'b1;
			end
		end
	end

	// Queue entry; a lone flush becomes the first result
	always_comb begin
		q_entry.row = row_q;
		if (res0_valid) begin
			q_entry.two   = eod && !row_ended;
			q_entry.kind0 = res0_kind;
			q_entry.byte0 = (res0_kind == KIND_BYTE) ? c : '0;
		end else begin
			q_entry.two   = 1'b0;
			q_entry.kind0 = KIND_ROW;
			q_entry.byte0 = '0;
		end
	end

	assign q_push = accept && (res0_valid || (eod && !row_ended));

	// Parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			fne_q  <= 1'b0;
			row_q  <= ROW_FIRST;
		end else if (accept) begin
			mode_q <= mode_d;
			fne_q  <= fne_d;
			row_q  <= row_d;
		end
	end

`ifndef SYNTH
	// A row ended by CR always starts an empty field
	a_cr_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_CRSEEN) |-> !fne_q)
		else $error("CR state with non-empty field");

	// Row counter never wraps to zero
	a_row_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		row_q != '0)
		else $error("row counter reached zero");

	// End of document returns the parser to its initial state
	a_eod_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && eod) |=> (mode_q == MODE_PLAIN && !fne_q && row_q == ROW_FIRST))
		else $error("state not restored after end of data");
`endif

endmodule

// File: rtl/csvp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvp_queue - small entry queue between front and back
// Register-based FIFO, one push and one pop per cycle.
// ----------------------------------------------------------------------------
module csvp_queue #(
	parameter int unsigned DEPTH = csvp_pkg::QDEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  csvp_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output csvp_pkg::entry_t head,
	output logic             empty
);
	import csvp_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_FULL);
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/csvp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvp_back - result sequencer
// Expands each queue entry into one or two results into an output register.
// ----------------------------------------------------------------------------
module csvp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  csvp_pkg::entry_t head,
	input  logic             q_empty,
	output logic             q_pop,
	csvp_out_if.source       out_ch
);
	import csvp_pkg::*;

	logic              out_valid_q;
	logic              sub_q;
	kind_t             kind_q;
	logic [BYTE_W-1:0] byte_q;
	logic [ROW_W-1:0]  row_q;
	logic              last_q;
	logic              load;
	logic              emit;

	assign load  = !out_valid_q || out_ch.ready;
	assign emit  = load && !q_empty;
	assign q_pop = emit && (sub_q || !head.two);

	assign out_ch.valid       = out_valid_q;
	assign out_ch.kind        = kind_q;
	assign out_ch.out_byte    = byte_q;
	assign out_ch.row_number  = row_q;
	assign out_ch.last_result = last_q;

	// Output valid and second-result pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sub_q       <= 1'b0;
		end else if (load) begin
			out_valid_q <= !q_empty;
			if (!q_empty) begin
				sub_q <= !sub_q && head.two;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			row_q <= head.row;
			if (sub_q) begin
				kind_q <= KIND_ROW;
				byte_q <= '0;
				last_q <= 1'b1;
			end else begin
				kind_q <= head.kind0;
				byte_q <= head.byte0;
				last_q <= !head.two;
			end
		end
	end

endmodule
